@@ hw/rtl/sqpd_pkg.sv @@
package sqpd_pkg;

    localparam int HEADER_BYTES = 5;
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);

    localparam logic [HDR_CNT_W-1:0] HDR_TYPE    = HDR_CNT_W'(0);
    localparam logic [HDR_CNT_W-1:0] HDR_SEQ_HI  = HDR_CNT_W'(1);
    localparam logic [HDR_CNT_W-1:0] HDR_SEQ_LO  = HDR_CNT_W'(2);
    localparam logic [HDR_CNT_W-1:0] HDR_SIZE_HI = HDR_CNT_W'(3);
    localparam logic [HDR_CNT_W-1:0] HDR_LAST    = HDR_CNT_W'(HEADER_BYTES - 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_TOLERANCE = 1'd1;

    localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd1019;
    localparam logic [15:0] SEQ_TOLERANCE_RST = 16'd256;

    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_SEQ_REJ = 2'd1;
    localparam logic [1:0] ST_SIZE_REJ = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SKIP    = 2'd2
    } t_phase;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  packet_type;
        logic [15:0] packet_seq;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        last;
    } t_result;

endpackage

@@ hw/rtl/sqpd_in_reg.sv @@
module sqpd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import sqpd_pkg::*;

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       w_accept;

    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ hw/rtl/sqpd_core.sv @@
module sqpd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sqpd_pkg::t_cfg_wr i_cfg,
    input  logic             i_advance,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output sqpd_pkg::t_result o_res
);
    import sqpd_pkg::*;

    logic [15:0]          r_max_payload;
    logic [15:0]          r_seq_tolerance;
    t_phase               r_phase;
    t_phase               n_phase;
    logic [HDR_CNT_W-1:0] r_header_count;
    logic [HDR_CNT_W-1:0] n_header_count;
    logic [7:0]           r_hdr_type;
    logic [7:0]           n_hdr_type;
    logic [15:0]          r_hdr_seq;
    logic [15:0]          n_hdr_seq;
    logic [15:0]          r_hdr_size;
    logic [15:0]          n_hdr_size;
    logic [15:0]          r_byte_count;
    logic [15:0]          n_byte_count;
    logic [15:0]          r_last_seq;
    logic [15:0]          n_last_seq;

    logic [16:0] w_count_inc;
    logic        w_count_done;
    logic        w_hdr_done;
    logic        w_seq_ok;
    logic        w_size_ok;
    logic        w_reject;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload   <= MAX_PAYLOAD_RST;
            r_seq_tolerance <= SEQ_TOLERANCE_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                CFG_MAX_PAYLOAD:   r_max_payload   <= i_cfg.data;
                CFG_SEQ_TOLERANCE: r_seq_tolerance <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // header assembly
    always_comb begin
        n_hdr_type = r_hdr_type;
        n_hdr_seq  = r_hdr_seq;
        n_hdr_size = r_hdr_size;
        if (r_phase != PH_PAYLOAD && r_phase != PH_SKIP) begin
            unique case (r_header_count)
                HDR_TYPE:    n_hdr_type = i_byte;
                HDR_SEQ_HI:  n_hdr_seq  = {i_byte, r_hdr_seq[7:0]};
                HDR_SEQ_LO:  n_hdr_seq  = {r_hdr_seq[15:8], i_byte};
                HDR_SIZE_HI: n_hdr_size = {i_byte, r_hdr_size[7:0]};
                default:     n_hdr_size = {r_hdr_size[15:8], i_byte};
            endcase
        end
    end

    assign w_count_inc  = {1'b0, r_byte_count} + 17'd1;
    assign w_count_done = w_count_inc >= {1'b0, r_hdr_size};
    assign w_hdr_done   = (r_header_count == HDR_LAST);
    // last_seq above 65535 - tolerance is last_seq > ~tolerance
    assign w_seq_ok     = ((r_last_seq > ~r_seq_tolerance) && (n_hdr_seq < r_seq_tolerance))
                          || (n_hdr_seq > r_last_seq);
    assign w_size_ok    = n_hdr_size <= r_max_payload;
    assign w_reject     = !w_seq_ok || !w_size_ok;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_PAYLOAD, PH_SKIP: begin
                if (w_count_done) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_phase = PH_HEADER;
                if (w_hdr_done) begin
                    if (w_reject) begin
                        n_phase = (n_hdr_size == 16'd0) ? PH_HEADER : PH_SKIP;
                    end else if (n_hdr_size != 16'd0) begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
        endcase
    end

    // counters, sequence commit and result
    always_comb begin
        n_header_count      = r_header_count;
        n_byte_count        = r_byte_count;
        n_last_seq          = r_last_seq;
        o_res_valid         = 1'b0;
        o_res.status        = ST_PAYLOAD;
        o_res.packet_type   = n_hdr_type;
        o_res.packet_seq    = n_hdr_seq;
        o_res.payload_byte  = 8'd0;
        o_res.payload_index = 16'd0;
        o_res.last          = 1'b0;
        unique case (r_phase)
            PH_PAYLOAD: begin
                o_res_valid         = 1'b1;
                o_res.payload_byte  = i_byte;
                o_res.payload_index = r_byte_count;
                o_res.last          = w_count_done;
                if (w_count_done) begin
                    n_last_seq   = r_hdr_seq;
                    n_byte_count = 16'd0;
                end else begin
                    n_byte_count = w_count_inc[15:0];
                end
            end
            PH_SKIP: begin
                n_byte_count = w_count_done ? 16'd0 : w_count_inc[15:0];
            end
            default: begin
                if (w_hdr_done) begin
                    n_header_count = '0;
                    n_byte_count   = 16'd0;
                    if (w_reject) begin
                        o_res_valid  = 1'b1;
                        o_res.status = (w_seq_ok ? ST_PAYLOAD : ST_SEQ_REJ)
                                       | (w_size_ok ? ST_PAYLOAD : ST_SIZE_REJ);
                        n_last_seq   = n_hdr_seq;
                    end
                end else begin
                    n_header_count = r_header_count + HDR_CNT_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_header_count <= '0;
            r_hdr_type     <= 8'd0;
            r_hdr_seq      <= 16'd0;
            r_hdr_size     <= 16'd0;
            r_byte_count   <= 16'd0;
            r_last_seq     <= 16'd0;
        end else if (i_advance) begin
            r_phase        <= n_phase;
            r_header_count <= n_header_count;
            r_hdr_type     <= n_hdr_type;
            r_hdr_seq      <= n_hdr_seq;
            r_hdr_size     <= n_hdr_size;
            r_byte_count   <= n_byte_count;
            r_last_seq     <= n_last_seq;
        end
    end

endmodule

@@ hw/rtl/sqpd_out_reg.sv @@
module sqpd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sqpd_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output sqpd_pkg::t_result o_res
);
    import sqpd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ hw/rtl/sequenced_packet_deframer.sv @@
// Packet deframer: one stream byte per transfer, one byte per clock sustained while the
// output is not stalled. Each packet is a 5-byte header (type, 16-bit sequence, 16-bit
// size, big-endian) then the payload. Accepted packets come out one payload byte per
// transfer, tagged with type, sequence and index, with last on the final byte. A header
// failing the sequence or size check yields one reject transfer and its payload is dropped;
// an accepted empty packet yields nothing. Each byte passes the input register and each
// result the result register; the input stalls only while output stall holds a result.
module sequenced_packet_deframer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sqpd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sqpd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_stream_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [7:0]                        o_packet_type,
    output logic [15:0]                       o_packet_seq,
    output logic [7:0]                        o_payload_byte,
    output logic [15:0]                       o_payload_index,
    output logic                              o_last
);
    import sqpd_pkg::*;

    t_cfg_wr    w_cfg;
    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_advance;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    assign w_advance = w_in_valid && (!o_out_valid || !i_out_stall);

    sqpd_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_byte    (i_stream_byte),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    sqpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_advance   (w_advance),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    sqpd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance && w_res_valid),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (w_out)
    );

    assign o_status        = w_out.status;
    assign o_packet_type   = w_out.packet_type;
    assign o_packet_seq    = w_out.packet_seq;
    assign o_payload_byte  = w_out.payload_byte;
    assign o_payload_index = w_out.payload_index;
    assign o_last          = w_out.last;

endmodule

@@ hw/rtl/sqpd_checker.sv @@
module sqpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [15:0] o_packet_seq,
    input logic [7:0]  o_payload_byte,
    input logic [15:0] o_payload_index,
    input logic        o_last
);
    import sqpd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_packet_seq))
        else $error("stalled result dropped or changed");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_PAYLOAD) |->
        (o_payload_byte == 8'd0) && (o_payload_index == 16'd0) && !o_last)
        else $error("reject transfer carries payload fields");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output free");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind sequenced_packet_deframer sqpd_checker u_sqpd_checker (.*);
